/* rtl/rse_pkg.sv */
package rse_pkg;

    // Field and datapath widths
    localparam int DataW   = 64;
    localparam int ExpW    = 11;
    localparam int FracW   = 52;
    localparam int IdxW    = 5;
    localparam int MulW    = 11;
    localparam int OffsetW = 26;
    localparam int StepW   = 11;
    localparam int ProdW   = StepW + MulW;
    localparam int DiffW   = 28;
    localparam int SumShift = 26;
    localparam int HighW   = DataW - SumShift;
    localparam int ExpCalcW = 13;

    // Bit-field positions in the operand
    localparam int IdxLsb = 48;
    localparam int MulLsb = 37;

    // Fixed encodings
    localparam logic [DataW-1:0]    QNAN_BITS    = 64'h7FF8_0000_0000_0000;
    localparam logic [ExpW-1:0]     EXP_ALL_ONES = 11'h7FF;
    localparam logic [ExpCalcW-1:0] EXP_BIAS     = 13'd1023;
    localparam logic [ExpCalcW-1:0] EXP_PIVOT    = 13'd1021;

    typedef logic [DataW-1:0] word_t;

    // Offset column of the seed table
    function automatic logic [OffsetW-1:0] rsq_offset(input logic [IdxW-1:0] idx);
        logic [OffsetW-1:0] v;
        begin
            case (idx)
                5'd0:  v = 26'h1a7e800;
                5'd1:  v = 26'h17cb800;
                5'd2:  v = 26'h1552800;
                5'd3:  v = 26'h130c000;
                5'd4:  v = 26'h10f2000;
                5'd5:  v = 26'h0eff000;
                5'd6:  v = 26'h0d2e000;
                5'd7:  v = 26'h0b7c000;
                5'd8:  v = 26'h09e5000;
                5'd9:  v = 26'h0867000;
                5'd10: v = 26'h06ff000;
                5'd11: v = 26'h05ab800;
                5'd12: v = 26'h046a000;
                5'd13: v = 26'h0339800;
                5'd14: v = 26'h0218800;
                5'd15: v = 26'h0105800;
                5'd16: v = 26'h3ffa000;
                5'd17: v = 26'h3c29000;
                5'd18: v = 26'h38aa000;
                5'd19: v = 26'h3572000;
                5'd20: v = 26'h3279000;
                5'd21: v = 26'h2fb7000;
                5'd22: v = 26'h2d26000;
                5'd23: v = 26'h2ac0000;
                5'd24: v = 26'h2881000;
                5'd25: v = 26'h2665000;
                5'd26: v = 26'h2468000;
                5'd27: v = 26'h2287000;
                5'd28: v = 26'h20c1000;
                5'd29: v = 26'h1f12000;
                5'd30: v = 26'h1d79000;
                5'd31: v = 26'h1bf4000;
                default: v = '0;
            endcase
            return v;
        end
    endfunction

    // Step column of the seed table
    function automatic logic [StepW-1:0] rsq_step(input logic [IdxW-1:0] idx);
        logic [StepW-1:0] v;
        begin
            case (idx)
                5'd0:  v = 11'h568;
                5'd1:  v = 11'h4f3;
                5'd2:  v = 11'h48d;
                5'd3:  v = 11'h435;
                5'd4:  v = 11'h3e7;
                5'd5:  v = 11'h3a2;
                5'd6:  v = 11'h365;
                5'd7:  v = 11'h32e;
                5'd8:  v = 11'h2fc;
                5'd9:  v = 11'h2d0;
                5'd10: v = 11'h2a8;
                5'd11: v = 11'h283;
                5'd12: v = 11'h261;
                5'd13: v = 11'h243;
                5'd14: v = 11'h226;
                5'd15: v = 11'h20b;
                5'd16: v = 11'h7a4;
                5'd17: v = 11'h700;
                5'd18: v = 11'h670;
                5'd19: v = 11'h5f2;
                5'd20: v = 11'h584;
                5'd21: v = 11'h524;
                5'd22: v = 11'h4cc;
                5'd23: v = 11'h47e;
                5'd24: v = 11'h43a;
                5'd25: v = 11'h3fa;
                5'd26: v = 11'h3c2;
                5'd27: v = 11'h38e;
                5'd28: v = 11'h35e;
                5'd29: v = 11'h332;
                5'd30: v = 11'h30a;
                5'd31: v = 11'h2e6;
                default: v = '0;
            endcase
            return v;
        end
    endfunction

endpackage

/* rtl/reciprocal_sqrt_estimate_top.sv */
// Reciprocal square root estimate of an IEEE 754 double bit pattern.
//
// Input channel: in_valid / in_stall with payload operand_bits. A beat is
// taken on a rising edge with in_valid high and in_stall low.
// Output channel: out_valid / out_stall with payload estimate_bits. A beat
// leaves on a rising edge with out_valid high and out_stall low.
//
// Registered stages, in order: table lookup and operand classification, the
// 11x11 step multiply, the offset subtract, then the exponent add into the
// output register. Throughput is one beat per cycle while the output is not
// stalled; the single multiplier stage sets the pipeline depth, not the rate.
//
// Zeros, infinities, NaNs and negative operands skip the arithmetic and
// ride the pipeline as a ready-made result.
//
// Reset clears all valid bits; the pipeline comes up empty and accepting.
// When the receiver stalls, the output beat holds and stages behind it keep
// advancing into empty slots; in_stall rises only once every stage is full.
module reciprocal_sqrt_estimate_top (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [rse_pkg::DataW-1:0] operand_bits,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [rse_pkg::DataW-1:0] estimate_bits
);
    import rse_pkg::*;

    // Stage 1: classification, table lookup, exponent
    logic                  s1_valid_reg, s1_valid_next;
    logic                  s1_special_reg, s1_special_next;
    word_t                 s1_spec_bits_reg, s1_spec_bits_next;
    logic [OffsetW-1:0]    s1_offset_reg, s1_offset_next;
    logic [StepW-1:0]      s1_step_reg, s1_step_next;
    logic [MulW-1:0]       s1_mul_reg, s1_mul_next;
    logic [ExpW-1:0]       s1_exp_reg, s1_exp_next;

    // Stage 2: product
    logic                  s2_valid_reg, s2_valid_next;
    logic                  s2_special_reg, s2_special_next;
    word_t                 s2_spec_bits_reg, s2_spec_bits_next;
    logic [OffsetW-1:0]    s2_offset_reg, s2_offset_next;
    logic [ProdW-1:0]      s2_prod_reg, s2_prod_next;
    logic [ExpW-1:0]       s2_exp_reg, s2_exp_next;

    // Stage 3: difference
    logic                  s3_valid_reg, s3_valid_next;
    logic                  s3_special_reg, s3_special_next;
    word_t                 s3_spec_bits_reg, s3_spec_bits_next;
    logic signed [DiffW-1:0] s3_diff_reg, s3_diff_next;
    logic [ExpW-1:0]       s3_exp_reg, s3_exp_next;

    // Output register
    logic                  out_valid_reg, out_valid_next;
    word_t                 out_bits_reg, out_bits_next;

    logic out_ready, s3_ready, s2_ready, s1_ready;

    // Stage k may load when empty or when its contents move on
    assign out_ready = !out_valid_reg || !out_stall;
    assign s3_ready  = !s3_valid_reg || out_ready;
    assign s2_ready  = !s2_valid_reg || s3_ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign in_stall  = !s1_ready;

    assign out_valid     = out_valid_reg;
    assign estimate_bits = out_bits_reg;

    // Classify the operand and look up the seed
    logic [ExpW-1:0]     op_exp;
    logic [IdxW-1:0]     op_idx;
    logic [ExpCalcW-1:0] exp_d;
    logic [ExpCalcW-1:0] exp_half;
    logic [ExpCalcW-1:0] exp_new;

    always_comb
    begin
        op_exp   = operand_bits[DataW-2 -: ExpW];
        op_idx   = operand_bits[IdxLsb +: IdxW];
        exp_d    = {{(ExpCalcW-ExpW){1'b0}}, op_exp} - EXP_PIVOT;
        exp_half = {exp_d[ExpCalcW-1], exp_d[ExpCalcW-1:1]};
        exp_new  = EXP_BIAS - exp_half;

        s1_valid_next     = s1_ready ? in_valid : s1_valid_reg;
        s1_offset_next    = rsq_offset(op_idx);
        s1_step_next      = rsq_step(op_idx);
        s1_mul_next       = operand_bits[MulLsb +: MulW];
        s1_exp_next       = exp_new[ExpW-1:0];
        s1_special_next   = 1'b1;
        s1_spec_bits_next = QNAN_BITS;

        if (operand_bits[DataW-2:0] == '0)
        begin
            // signed zero: infinity of the same sign
            s1_spec_bits_next = {operand_bits[DataW-1], EXP_ALL_ONES, {FracW{1'b0}}};
        end
        else if (op_exp == EXP_ALL_ONES)
        begin
            if (operand_bits[FracW-1:0] == '0)
                s1_spec_bits_next = operand_bits[DataW-1] ? QNAN_BITS : '0;
            else
                s1_spec_bits_next = operand_bits;
        end
        else if (!operand_bits[DataW-1])
        begin
            s1_special_next = 1'b0;
        end
    end

    // Multiply step by the mantissa slice
    always_comb
    begin
        s2_valid_next     = s2_ready ? s1_valid_reg : s2_valid_reg;
        s2_special_next   = s1_special_reg;
        s2_spec_bits_next = s1_spec_bits_reg;
        s2_offset_next    = s1_offset_reg;
        s2_exp_next       = s1_exp_reg;
        s2_prod_next      = ProdW'(s1_step_reg) * ProdW'(s1_mul_reg);
    end

    // Subtract the product from the offset
    always_comb
    begin
        s3_valid_next     = s3_ready ? s2_valid_reg : s3_valid_reg;
        s3_special_next   = s2_special_reg;
        s3_spec_bits_next = s2_spec_bits_reg;
        s3_exp_next       = s2_exp_reg;
        s3_diff_next      = signed'(DiffW'(s2_offset_reg)) - signed'(DiffW'(s2_prod_reg));
    end

    // Add the scaled difference to the base exponent word
    logic [HighW-1:0] base_high;
    logic [HighW-1:0] diff_ext;
    logic [HighW-1:0] sum_high;

    always_comb
    begin
        base_high      = {1'b0, s3_exp_reg, {(HighW-ExpW-1){1'b0}}};
        diff_ext       = {{(HighW-DiffW){s3_diff_reg[DiffW-1]}}, s3_diff_reg};
        sum_high       = base_high + diff_ext;
        out_valid_next = out_ready ? s3_valid_reg : out_valid_reg;
        out_bits_next  = s3_special_reg ? s3_spec_bits_reg : {sum_high, {SumShift{1'b0}}};
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            s3_valid_reg  <= s3_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload: advance each stage when it is free to load
    always_ff @(posedge clk)
    begin
        if (s1_ready && in_valid)
        begin
            s1_special_reg   <= s1_special_next;
            s1_spec_bits_reg <= s1_spec_bits_next;
            s1_offset_reg    <= s1_offset_next;
            s1_step_reg      <= s1_step_next;
            s1_mul_reg       <= s1_mul_next;
            s1_exp_reg       <= s1_exp_next;
        end
        if (s2_ready && s1_valid_reg)
        begin
            s2_special_reg   <= s2_special_next;
            s2_spec_bits_reg <= s2_spec_bits_next;
            s2_offset_reg    <= s2_offset_next;
            s2_prod_reg      <= s2_prod_next;
            s2_exp_reg       <= s2_exp_next;
        end
        if (s3_ready && s2_valid_reg)
        begin
            s3_special_reg   <= s3_special_next;
            s3_spec_bits_reg <= s3_spec_bits_next;
            s3_diff_reg      <= s3_diff_next;
            s3_exp_reg       <= s3_exp_next;
        end
        if (out_ready && s3_valid_reg)
        begin
            out_bits_reg <= out_bits_next;
        end
    end

    // An empty first stage always takes a beat
    a_empty_accepts: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> !in_stall)
        else $error("input stalled with empty first stage");

    // A result in the last stage fills an empty output slot
    a_out_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (s3_valid_reg && !out_valid_reg) |=> out_valid_reg)
        else $error("last stage result not moved to empty output");

    // An item in stage 2 is never dropped on its way forward
    a_s2_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid_reg && s3_ready) |=> s3_valid_reg)
        else $error("stage 2 item lost");

    // A stalled output holds its beat
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> (out_valid_reg && $stable(out_bits_reg)))
        else $error("stalled output beat changed");

endmodule
